### rtl/sder_pkg.sv
// Shared types, constants and ASCII lookup tables for the scancode decode event ring.
// Used by the interfaces, the front end, the command queue and the back end.
// No dependencies.
package sder_pkg;

    localparam int CODE_W   = 8;
    localparam int CHAR_W   = 7;
    localparam int TIME_W   = 32;
    localparam int TICK_W   = 48;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 11;

    localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK = 8'hB6;

    localparam logic REQ_SCANCODE = 1'b0;
    localparam logic REQ_READ     = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED     = 3'd0,
        ST_OVERWRITE  = 3'd1,
        ST_IGNORED    = 3'd2,
        ST_READ_OK    = 3'd3,
        ST_READ_EMPTY = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_STORE,
        OP_IGNORE,
        OP_READ
    } op_t;

    typedef enum logic {
        BK_RUN,
        BK_FETCH
    } back_state_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] ch;
        logic [TIME_W-1:0] time_seconds;
        logic [TICK_W-1:0] idle_ticks;
        logic [TICK_W-1:0] iowait_ticks;
        logic              shift;
    } cmd_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [TIME_W-1:0] time_seconds;
        logic [TICK_W-1:0] idle_ticks;
        logic [TICK_W-1:0] iowait_ticks;
    } event_t;

    localparam int EVENT_W = $bits(event_t);

    function automatic logic [CHAR_W-1:0] plain_char(input logic [6:0] code);
        logic [CHAR_W-1:0] c;
        unique case (code)
            7'h02: c = 7'h31;
            7'h03: c = 7'h32;
            7'h04: c = 7'h33;
            7'h05: c = 7'h34;
            7'h06: c = 7'h35;
            7'h07: c = 7'h36;
            7'h08: c = 7'h37;
            7'h09: c = 7'h38;
            7'h0A: c = 7'h39;
            7'h0B: c = 7'h30;
            7'h0C: c = 7'h2D;
            7'h0D: c = 7'h3D;
            7'h0E: c = 7'h08;
            7'h0F: c = 7'h09;
            7'h10: c = 7'h71;
            7'h11: c = 7'h77;
            7'h12: c = 7'h65;
            7'h13: c = 7'h72;
            7'h14: c = 7'h74;
            7'h15: c = 7'h79;
            7'h16: c = 7'h75;
            7'h17: c = 7'h69;
            7'h18: c = 7'h6F;
            7'h19: c = 7'h70;
            7'h1C: c = 7'h0A;
            7'h1E: c = 7'h61;
            7'h1F: c = 7'h73;
            7'h20: c = 7'h64;
            7'h21: c = 7'h66;
            7'h22: c = 7'h67;
            7'h23: c = 7'h68;
            7'h24: c = 7'h6A;
            7'h25: c = 7'h6B;
            7'h26: c = 7'h6C;
            7'h2C: c = 7'h7A;
            7'h2D: c = 7'h78;
            7'h2E: c = 7'h63;
            7'h2F: c = 7'h76;
            7'h30: c = 7'h62;
            7'h31: c = 7'h6E;
            7'h32: c = 7'h6D;
            7'h33: c = 7'h2C;
            7'h34: c = 7'h2E;
            7'h35: c = 7'h2F;
            7'h39: c = 7'h20;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] shifted_char(input logic [6:0] code);
        logic [CHAR_W-1:0] c;
        unique case (code)
            7'h02: c = 7'h21;
            7'h03: c = 7'h40;
            7'h04: c = 7'h23;
            7'h05: c = 7'h24;
            7'h06: c = 7'h25;
            7'h07: c = 7'h5E;
            7'h08: c = 7'h26;
            7'h09: c = 7'h2A;
            7'h0A: c = 7'h28;
            7'h0B: c = 7'h29;
            7'h0C: c = 7'h5F;
            7'h0D: c = 7'h2B;
            7'h10: c = 7'h51;
            7'h11: c = 7'h57;
            7'h12: c = 7'h45;
            7'h13: c = 7'h52;
            7'h14: c = 7'h54;
            7'h15: c = 7'h59;
            7'h16: c = 7'h55;
            7'h17: c = 7'h49;
            7'h18: c = 7'h4F;
            7'h19: c = 7'h50;
            7'h1C: c = 7'h0A;
            7'h1E: c = 7'h41;
            7'h1F: c = 7'h53;
            7'h20: c = 7'h44;
            7'h21: c = 7'h46;
            7'h22: c = 7'h47;
            7'h23: c = 7'h48;
            7'h24: c = 7'h4A;
            7'h25: c = 7'h4B;
            7'h26: c = 7'h4C;
            7'h2C: c = 7'h5A;
            7'h2D: c = 7'h58;
            7'h2E: c = 7'h43;
            7'h2F: c = 7'h56;
            7'h30: c = 7'h42;
            7'h31: c = 7'h4E;
            7'h32: c = 7'h4D;
            7'h33: c = 7'h3C;
            7'h34: c = 7'h3E;
            7'h35: c = 7'h3F;
            7'h39: c = 7'h20;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

### rtl/sder_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on sder_pkg for field widths.
interface sder_req_if;
    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic [sder_pkg::CODE_W-1:0]     scancode;
    logic [sder_pkg::TIME_W-1:0]     time_seconds;
    logic [sder_pkg::TICK_W-1:0]     idle_ticks;
    logic [sder_pkg::TICK_W-1:0]     iowait_ticks;

    modport source (
        output valid, req_type, scancode, time_seconds, idle_ticks, iowait_ticks,
        input  ready
    );
    modport sink (
        input  valid, req_type, scancode, time_seconds, idle_ticks, iowait_ticks,
        output ready
    );
endinterface

interface sder_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [sder_pkg::STATUS_W-1:0]   status;
    logic [sder_pkg::CHAR_W-1:0]     char_out;
    logic [sder_pkg::TIME_W-1:0]     time_out;
    logic [sder_pkg::TICK_W-1:0]     idle_out;
    logic [sder_pkg::TICK_W-1:0]     iowait_out;
    logic                            shift_now;
    logic [sder_pkg::FILL_W-1:0]     fill_level;

    modport source (
        output valid, status, char_out, time_out, idle_out, iowait_out, shift_now,
               fill_level,
        input  ready
    );
    modport sink (
        input  valid, status, char_out, time_out, idle_out, iowait_out, shift_now,
               fill_level,
        output ready
    );
endinterface

### rtl/sder_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module sder_ram #(
    parameter int WIDTH = 135,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/sder_front.sv
// Front end: accepts requests, tracks the shift flag and classifies each item.
// Depends on sder_pkg and sder_if.
module sder_front (
    input  logic                 clk,
    input  logic                 rst_n,
    sder_req_if.sink             req,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output sder_pkg::cmd_t       cmd
);
    import sder_pkg::*;

    logic              shift_reg;
    logic              shift_next;
    logic [CHAR_W-1:0] lookup_char;

    assign lookup_char = shift_reg ? shifted_char(req.scancode[6:0])
                                   : plain_char(req.scancode[6:0]);

    always_comb
    begin
        shift_next       = shift_reg;
        cmd.op           = OP_IGNORE;
        cmd.ch           = '0;
        cmd.time_seconds = req.time_seconds;
        cmd.idle_ticks   = req.idle_ticks;
        cmd.iowait_ticks = req.iowait_ticks;
        if (req.req_type == REQ_READ)
        begin
            cmd.op = OP_READ;
        end
        else if (req.scancode == SC_LSHIFT_MAKE || req.scancode == SC_RSHIFT_MAKE)
        begin
            shift_next = 1'b1;
        end
        else if (req.scancode == SC_LSHIFT_BREAK || req.scancode == SC_RSHIFT_BREAK)
        begin
            shift_next = 1'b0;
        end
        else if (!req.scancode[7] && lookup_char != '0)
        begin
            cmd.op = OP_STORE;
            cmd.ch = lookup_char;
        end
        cmd.shift = shift_next;
    end

    assign cmd_valid = req.valid;
    assign req.ready = cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
        end
        else if (req.valid && cmd_ready)
        begin
            shift_reg <= shift_next;
        end
    end

endmodule

### rtl/sder_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on sder_pkg.
module sder_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sder_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output sder_pkg::cmd_t out_cmd
);
    import sder_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_idx_reg;
    logic       wr_idx_next;
    logic       rd_idx_reg;
    logic       rd_idx_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = entry_reg[rd_idx_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_idx_next = push ? ~wr_idx_reg : wr_idx_reg;
        rd_idx_next = pop ? ~rd_idx_reg : rd_idx_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= 1'b0;
            rd_idx_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_idx_reg] <= in_cmd;
        end
    end

endmodule

### rtl/sder_back.sv
// Back end: carries out store and read commands on the event ring and drives results.
// Depends on sder_pkg, sder_if and sder_ram.
module sder_back #(
    parameter int RING_DEPTH = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  sder_pkg::cmd_t cmd,
    sder_rsp_if.source     rsp
);
    import sder_pkg::*;

    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int FILL_EXT_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              pend_shift_reg;
    logic              pend_shift_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    status_t           out_status_reg;
    status_t           out_status_next;
    logic [CHAR_W-1:0] out_char_reg;
    logic [CHAR_W-1:0] out_char_next;
    logic [TIME_W-1:0] out_time_reg;
    logic [TIME_W-1:0] out_time_next;
    logic [TICK_W-1:0] out_idle_reg;
    logic [TICK_W-1:0] out_idle_next;
    logic [TICK_W-1:0] out_iowait_reg;
    logic [TICK_W-1:0] out_iowait_next;
    logic              out_shift_reg;
    logic              out_shift_next;
    logic [FILL_W-1:0] out_fill_reg;
    logic [FILL_W-1:0] out_fill_next;

    logic              out_free;
    logic              out_load;
    logic [PTR_W-1:0]  wr_ptr_inc;
    logic [PTR_W-1:0]  rd_ptr_inc;
    logic [FILL_EXT_W-1:0] count_ext;

    logic              ram_wr_en;
    logic              ram_rd_en;
    event_t            wr_event;
    logic [EVENT_W-1:0] ram_rd_data;
    event_t            rd_event;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign count_ext  = FILL_EXT_W'(count_next);
    assign rd_event   = event_t'(ram_rd_data);

    assign wr_event.ch           = cmd.ch;
    assign wr_event.time_seconds = cmd.time_seconds;
    assign wr_event.idle_ticks   = cmd.idle_ticks;
    assign wr_event.iowait_ticks = cmd.iowait_ticks;

    sder_ram #(
        .WIDTH (EVENT_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (wr_event),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_RUN:
            begin
                if (cmd_valid && out_free && cmd.op == OP_READ && count_reg != '0)
                begin
                    state_next = BK_FETCH;
                end
            end
            BK_FETCH:
            begin
                state_next = BK_RUN;
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_comb
    begin
        cmd_ready       = 1'b0;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        out_load        = 1'b0;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        count_next      = count_reg;
        pend_shift_next = pend_shift_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_char_next   = out_char_reg;
        out_time_next   = out_time_reg;
        out_idle_next   = out_idle_reg;
        out_iowait_next = out_iowait_reg;
        out_shift_next  = out_shift_reg;
        unique case (state_reg)
            BK_RUN:
            begin
                cmd_ready = out_free;
                if (cmd_valid && out_free)
                begin
                    out_load        = 1'b1;
                    out_valid_next  = 1'b1;
                    out_char_next   = cmd.ch;
                    out_time_next   = '0;
                    out_idle_next   = '0;
                    out_iowait_next = '0;
                    out_shift_next  = cmd.shift;
                    unique case (cmd.op)
                        OP_STORE:
                        begin
                            ram_wr_en   = 1'b1;
                            wr_ptr_next = wr_ptr_inc;
                            if (count_reg == CNT_FULL)
                            begin
                                rd_ptr_next     = rd_ptr_inc;
                                out_status_next = ST_OVERWRITE;
                            end
                            else
                            begin
                                count_next      = count_reg + 1'b1;
                                out_status_next = ST_STORED;
                            end
                        end
                        OP_READ:
                        begin
                            out_char_next = '0;
                            if (count_reg != '0)
                            begin
                                ram_rd_en       = 1'b1;
                                rd_ptr_next     = rd_ptr_inc;
                                count_next      = count_reg - 1'b1;
                                pend_shift_next = cmd.shift;
                                out_load        = 1'b0;
                                out_valid_next  = 1'b0;
                            end
                            else
                            begin
                                out_status_next = ST_READ_EMPTY;
                            end
                        end
                        default:
                        begin
                            out_status_next = ST_IGNORED;
                        end
                    endcase
                end
            end
            BK_FETCH:
            begin
                out_load        = 1'b1;
                out_valid_next  = 1'b1;
                out_status_next = ST_READ_OK;
                out_char_next   = rd_event.ch;
                out_time_next   = rd_event.time_seconds;
                out_idle_next   = rd_event.idle_ticks;
                out_iowait_next = rd_event.iowait_ticks;
                out_shift_next  = pend_shift_reg;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    assign out_fill_next = out_load ? count_ext[FILL_W-1:0] : out_fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_shift_reg <= pend_shift_next;
        out_status_reg <= out_status_next;
        out_char_reg   <= out_char_next;
        out_time_reg   <= out_time_next;
        out_idle_reg   <= out_idle_next;
        out_iowait_reg <= out_iowait_next;
        out_shift_reg  <= out_shift_next;
        out_fill_reg   <= out_fill_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.char_out   = out_char_reg;
    assign rsp.time_out   = out_time_reg;
    assign rsp.idle_out   = out_idle_reg;
    assign rsp.iowait_out = out_iowait_reg;
    assign rsp.shift_now  = out_shift_reg;
    assign rsp.fill_level = out_fill_reg;

endmodule

### rtl/scancode_decode_event_ring.sv
// Top level of the scancode decode event ring: front end, command queue and back end.
// Depends on sder_pkg, sder_if, sder_front, sder_queue and sder_back.
//
// Each item on req is either a set-1 scancode with its timestamp and tick counts, or a
// read of the oldest stored event. Every item gives exactly one item on rsp, in order.
// The front end decodes the code and tracks shift in the cycle the item is accepted,
// and hands a command to a two-entry queue. The back end takes one command a cycle while
// its output register is free and it is not fetching a read from the ring. A result is
// registered in the queue and the output register; a read that returns an event also
// passes the ring RAM's registered read. Arrivals and empty reads sustain one item per
// cycle while rsp is not stalled; a read that returns an event stalls it in its fetch state.
// Reset clears the shift flag, the ring pointers and the held count at once; the ring
// contents are not cleared and no entry is read before it is written.
// When rsp is stalled the result waits in the output register, the queue fills, and
// req.ready falls once both queue entries are taken.
module scancode_decode_event_ring #(
    parameter int RING_DEPTH = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    sder_req_if.sink   req,
    sder_rsp_if.source rsp
);
    import sder_pkg::*;

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic back_valid;
    logic back_ready;
    cmd_t back_cmd;

    sder_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    sder_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_cmd   (back_cmd)
    );

    sder_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .rsp       (rsp)
    );

endmodule
